[hw/rtl/fdf_pkg.sv]
// ----------------------------------------------------------------------------
// fdf_pkg
// shared types, widths and the fixed q16 coefficient table of the fir filter
// ----------------------------------------------------------------------------
package fdf_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 16;
    localparam int OUT_W        = 32;
    // sum of |coef| is below 2^18, so 24 + 18 bits plus sign fit with margin
    localparam int ACC_W        = 48;
    localparam int OUT_SHIFT    = 9;
    localparam int ROM_DEPTH    = 64;
    localparam int ROM_AW       = $clog2(ROM_DEPTH);
    localparam int TAPS_DEFAULT = 64;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [OUT_W-1:0]    t_out;

    localparam t_coef COEF_ROM [ROM_DEPTH] = '{
        -16'sd131,   -16'sd331,   -16'sd546,   -16'sd691,
        -16'sd609,   -16'sd305,    16'sd139,    16'sd473,
         16'sd512,    16'sd181,   -16'sd318,   -16'sd669,
        -16'sd578,    -16'sd45,    16'sd629,    16'sd959,
         16'sd638,   -16'sd237,  -16'sd1117,  -16'sd1347,
        -16'sd594,    16'sd800,   16'sd1943,   16'sd1882,
         16'sd308,  -16'sd2064,  -16'sd3678,  -16'sd2925,
         16'sd902,   16'sd7010,  16'sd13295,  16'sd17269,
        16'sd17269,  16'sd13295,   16'sd7010,    16'sd902,
        -16'sd2925,  -16'sd3678,  -16'sd2064,    16'sd308,
         16'sd1882,   16'sd1943,    16'sd800,   -16'sd594,
        -16'sd1347,  -16'sd1117,   -16'sd237,    16'sd638,
          16'sd959,    16'sd629,    -16'sd45,   -16'sd578,
         -16'sd669,   -16'sd318,    16'sd181,    16'sd512,
          16'sd473,    16'sd139,   -16'sd305,   -16'sd609,
         -16'sd691,   -16'sd546,   -16'sd331,   -16'sd131
    };

    // taps past the end of the table weigh zero
    function automatic t_coef coef_at(input int k);
        t_coef c;
        c = '0;
        if (k >= 0 && k < ROM_DEPTH) begin
            c = COEF_ROM[k[ROM_AW-1:0]];
        end
        return c;
    endfunction

endpackage

[hw/rtl/fir_denoise_filter_top.sv]
// ----------------------------------------------------------------------------
// fir_denoise_filter_top
// symmetric low-pass fir for 24-bit audio, one sample in, one filtered out
// ----------------------------------------------------------------------------
// The filter takes one signed 24-bit sample per item and returns one signed
// 32-bit item: the sum of the fixed q16 coefficients times the current and
// the previous TAPS-1 samples, shifted right arithmetically by nine and
// saturated. It is built in transposed form as a row of TAPS-1 cells, each
// holding one partial sum that moves one cell toward the output on every
// accepted item; the partial sums start at zero, so the history before the
// first items counts as silence. It accepts one item every clock cycle while
// o_ready is high; the result is written into a two-entry output buffer at the
// edge that accepts the item and is offered on the next cycle. The figure is set
// by each cell doing one 24x16 multiply and one add per item. o_ready drops only
// while both buffer entries hold results the downstream side has not yet taken.
// ----------------------------------------------------------------------------
module fir_denoise_filter_top #(
    parameter int TAPS = fdf_pkg::TAPS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input item channel
    input  logic             i_valid,
    output logic             o_ready,
    input  fdf_pkg::t_sample i_sample_in,
    // result item channel
    output logic             o_valid,
    input  logic             i_ready,
    output fdf_pkg::t_out    o_filtered_out
);
    import fdf_pkg::*;

    logic w_accept;
    logic w_full;
    // partial sums along the chain; the far end feeds zero
    t_acc w_psum [1:TAPS];

    assign o_ready       = !w_full;
    assign w_accept      = i_valid && o_ready;
    assign w_psum[TAPS]  = '0;

    // cell k adds coef[k] * x to the sum coming from cell k+1
    for (genvar k = 1; k < TAPS; k++) begin : g_tap
        fdf_cell #(
            .COEF (coef_at(k))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_accept),
            .i_x     (i_sample_in),
            .i_sum   (w_psum[k+1]),
            .o_sum   (w_psum[k])
        );
    end

    // tap zero, scaling and output buffering
    fdf_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_x     (i_sample_in),
        .i_psum  (w_psum[1]),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (o_filtered_out),
        .o_full  (w_full)
    );

endmodule

[hw/rtl/fdf_cell.sv]
// ----------------------------------------------------------------------------
// fdf_cell
// one tap of the transposed fir chain: multiply, add neighbor sum, register
// ----------------------------------------------------------------------------
module fdf_cell #(
    parameter fdf_pkg::t_coef COEF = '0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fdf_pkg::t_sample i_x,
    input  fdf_pkg::t_acc   i_sum,
    output fdf_pkg::t_acc   o_sum
);
    import fdf_pkg::*;

    logic signed [SAMPLE_W+COEF_W-1:0] w_prod;
    t_acc r_sum;
    t_acc n_sum;

    assign w_prod = i_x * COEF;
    assign n_sum  = i_sum + t_acc'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[hw/rtl/fdf_out_stage.sv]
// ----------------------------------------------------------------------------
// fdf_out_stage
// tap zero, scaling shift, saturation and a two-entry output buffer
// ----------------------------------------------------------------------------
module fdf_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fdf_pkg::t_sample i_x,
    input  fdf_pkg::t_acc    i_psum,
    input  logic             i_ready,
    output logic             o_valid,
    output fdf_pkg::t_out    o_data,
    output logic             o_full
);
    import fdf_pkg::*;

    localparam t_coef COEF0 = coef_at(0);

    logic signed [SAMPLE_W+COEF_W-1:0] w_prod;
    t_acc  w_total;
    t_acc  w_shift;
    t_out  w_sat;
    logic  w_pop;

    t_out        r_mem [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;

    assign w_prod  = i_x * COEF0;
    assign w_total = i_psum + t_acc'(w_prod);
    assign w_shift = w_total >>> OUT_SHIFT;

    // saturate when the bits above the result disagree with its sign
    always_comb begin
        if (&w_shift[ACC_W-1:OUT_W-1] || ~|w_shift[ACC_W-1:OUT_W-1]) begin
            w_sat = w_shift[OUT_W-1:0];
        end else if (w_shift[ACC_W-1]) begin
            w_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        unique case ({i_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

endmodule

[hw/rtl/fdf_checker.sv]
// ----------------------------------------------------------------------------
// fdf_checker
// port-level checks of the fir filter, bound to the top level
// ----------------------------------------------------------------------------
module fdf_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input fdf_pkg::t_out    o_filtered_out
);

    // no result is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

    // an accepted item always leaves a result to offer next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted item produced no result");

    // the buffer can only be full while it offers a result
    a_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with nothing to deliver");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_filtered_out)))
        else $error("stalled result changed");

endmodule

bind fir_denoise_filter_top fdf_checker u_fdf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_filtered_out (o_filtered_out)
);

[tb/tb_fir_denoise_filter_top.sv]
// ----------------------------------------------------------------------------
// tb_fir_denoise_filter_top
// self-checking bench for the 64-tap symmetric low-pass fir
// ----------------------------------------------------------------------------
// Sends a short table of directed samples right after reset (impulse, silence,
// full-scale extremes), then about 1800 random samples: uniform noise, small
// values, constant runs, extremes and 64-sample bursts whose signs follow the
// coefficients, so the sum reaches its largest magnitude. Every accepted
// sample runs through a local model of the filter, and every result item is
// compared with the oldest expected value. Both channels idle at random, and
// the result side holds off once for a long stretch so the block fills up
// and stalls its input.
// ----------------------------------------------------------------------------
module tb_fir_denoise_filter_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_TAPS       = 64;
    localparam int N_DIRECTED   = 22;
    localparam int N_RANDOM     = 1828;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    localparam fdf_pkg::t_sample SAMPLE_MAX = 24'sh7fffff;
    localparam fdf_pkg::t_sample SAMPLE_MIN = -24'sh800000;
    localparam longint           OUT_MAX    = 64'sh7fffffff;
    localparam longint           OUT_MIN    = -64'sh80000000;

    // first half of the q16 taps, the second half mirrors it
    localparam int HALF_TAPS [32] = '{
        -131,  -331,  -546,  -691,  -609,  -305,   139,   473,
         512,   181,  -318,  -669,  -578,   -45,   629,   959,
         638,  -237, -1117, -1347,  -594,   800,  1943,  1882,
         308, -2064, -3678, -2925,   902,  7010, 13295, 17269
    };

    // one directed item; filtered is only used where known is set
    typedef struct packed {
        logic signed [23:0] sample;
        logic               known;
        logic signed [31:0] filtered;
    } t_stim_row;

    // impulse of 512 after reset gives the coefficients themselves
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{24'sd0,        1'b1, 32'sd0},
        '{24'sd512,      1'b1, -32'sd131},
        '{24'sd0,        1'b1, -32'sd331},
        '{24'sd0,        1'b1, -32'sd546},
        '{24'sd0,        1'b1, -32'sd691},
        '{24'sd0,        1'b1, -32'sd609},
        '{24'sd8388607,  1'b0, 32'sd0},
        '{-24'sd8388608, 1'b0, 32'sd0},
        '{-24'sd1,       1'b0, 32'sd0},
        '{24'sd1,        1'b0, 32'sd0},
        '{24'sd8388607,  1'b0, 32'sd0},
        '{24'sd8388607,  1'b0, 32'sd0},
        '{-24'sd8388608, 1'b0, 32'sd0},
        '{-24'sd8388608, 1'b0, 32'sd0},
        '{24'sd5592405,  1'b0, 32'sd0},
        '{-24'sd5592406, 1'b0, 32'sd0},
        '{24'sd1,        1'b0, 32'sd0},
        '{-24'sd1,       1'b0, 32'sd0},
        '{24'sd0,        1'b0, 32'sd0},
        '{24'sd8388607,  1'b0, 32'sd0},
        '{-24'sd8388608, 1'b0, 32'sd0},
        '{24'sd0,        1'b0, 32'sd0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    fdf_pkg::t_sample i_sample_in;
    logic             o_valid;
    logic             i_ready;
    fdf_pkg::t_out    o_filtered_out;

    // local model state: previous samples, newest first
    fdf_pkg::t_sample sample_history [N_TAPS-1];
    // filtered values still owed by the block, oldest first
    fdf_pkg::t_out    expected_filtered_q [$];

    int  cycle_count;
    int  sent_count;
    int  result_count;
    int  fail_count;
    int  report_count;
    bit  held_off;

    fir_denoise_filter_top #(
        .TAPS(N_TAPS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_in    (i_sample_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_filtered_out (o_filtered_out)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // q16 weight of tap k, symmetric around the middle
    function automatic int tap_weight(input int k);
        int w;
        w = 0;
        if (k >= 0 && k < 32) begin
            w = HALF_TAPS[k];
        end else if (k >= 32 && k < 64) begin
            w = HALF_TAPS[63 - k];
        end
        return w;
    endfunction

    // filter one new sample: weighted sum, floor shift by nine, saturate,
    // then push the sample into the history
    function automatic fdf_pkg::t_out fir_predict_next(input fdf_pkg::t_sample x);
        longint acc;
        longint y;
        acc = longint'(tap_weight(0)) * longint'(x);
        for (int k = 1; k < N_TAPS; k++) begin
            acc += longint'(tap_weight(k)) * longint'(sample_history[k-1]);
        end
        y = acc >>> fdf_pkg::OUT_SHIFT;
        if (y > OUT_MAX) y = OUT_MAX;
        if (y < OUT_MIN) y = OUT_MIN;
        for (int k = N_TAPS - 2; k > 0; k--) begin
            sample_history[k] = sample_history[k-1];
        end
        sample_history[0] = x;
        return fdf_pkg::t_out'(y);
    endfunction

    // idle length: mostly none, often short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_failure(input string what, input fdf_pkg::t_out want,
                                  input fdf_pkg::t_out got);
        fail_count++;
        if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%s at cycle %0d: expected %0d, got %0d",
                     what, cycle_count, want, got);
        end
    endtask

    // offer one item and hold it until accepted; no gap inside the
    // no-idle window so valid stays high across back-to-back items
    task automatic send_item(input fdf_pkg::t_sample s, input bit known,
                             input fdf_pkg::t_out typed);
        int gap;
        fdf_pkg::t_out predicted;
        gap = (sent_count >= 900 && sent_count < 1100) ? 0 : pick_idle();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (!o_ready);
        predicted = fir_predict_next(s);
        expected_filtered_q.push_back(known ? typed : predicted);
        sent_count++;
    endtask

    // generous cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("fir_denoise_filter_top: mismatch");
            $finish;
        end
    end

    // result side: compare each accepted item with the oldest expectation
    always @(posedge i_clk) begin
        fdf_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            result_count <= result_count + 1;
            if (expected_filtered_q.size() == 0) begin
                report_failure("unexpected item", '0, o_filtered_out);
            end else begin
                want = expected_filtered_q.pop_front();
                if (o_filtered_out !== want) begin
                    report_failure("filtered_out", want, o_filtered_out);
                end
            end
        end
    end

    // result side readiness: random stalls, a clean window, and one long
    // hold-off while the sender keeps offering items
    initial begin
        int run;
        int stall;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            run = $urandom_range(1, 20);
            i_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (!held_off && result_count >= 500) begin
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = (result_count >= 1200 && result_count < 1400) ? 0 : pick_idle();
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // input side: reset, directed table, random samples, drain, verdict
    initial begin
        int               burst_left;
        bit               burst_neg;
        int               r;
        fdf_pkg::t_sample s;
        fdf_pkg::t_sample last_s;
        logic [23:0]      raw;

        cycle_count  = 0;
        sent_count   = 0;
        result_count = 0;
        fail_count   = 0;
        report_count = 0;
        held_off     = 1'b0;
        burst_left   = 0;
        burst_neg    = 1'b0;
        last_s       = '0;
        foreach (sample_history[k]) sample_history[k] = '0;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample_in <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, starting from a cleared history
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(DIRECTED[i].sample, DIRECTED[i].known, DIRECTED[i].filtered);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (burst_left > 0) begin
                // signs follow the taps so the sum peaks at the burst end
                s = ((tap_weight(N_TAPS - burst_left) >= 0) ^ burst_neg)
                    ? SAMPLE_MAX : SAMPLE_MIN;
                burst_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    burst_left = N_TAPS - 1;
                    burst_neg  = 1'($urandom_range(0, 1));
                    s = ((tap_weight(0) >= 0) ^ burst_neg) ? SAMPLE_MAX : SAMPLE_MIN;
                end else if (r < 45) begin
                    raw = 24'($urandom_range(0, 24'hffffff));
                    s   = fdf_pkg::t_sample'(raw);
                end else if (r < 65) begin
                    case ($urandom_range(0, 4))
                        0:       s = SAMPLE_MAX;
                        1:       s = SAMPLE_MIN;
                        2:       s = '0;
                        3:       s = -24'sd1;
                        default: s = 24'sd1;
                    endcase
                end else if (r < 85) begin
                    s = fdf_pkg::t_sample'($urandom_range(0, 2000)) - 24'sd1000;
                end else begin
                    // constant run
                    s = last_s;
                end
            end
            last_s = s;
            send_item(s, 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (expected_filtered_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        fail_count += expected_filtered_q.size();
        if (fail_count == 0) begin
            $display("fir_denoise_filter_top: match");
        end else begin
            $display("fir_denoise_filter_top: mismatch");
        end
        $finish;
    end

endmodule
